// ===== design/dhf_pkg.sv =====
// Shared types, constants and the arctangent table of the distance-hold follower.
package dhf_pkg;

  localparam int unsigned OFS_W    = 16;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned HOLD_W   = 15;
  localparam int unsigned CAP_W    = 15;
  localparam int unsigned STALE_W  = 16;
  localparam int unsigned SPEED_W  = 15;
  localparam int unsigned TURN_W   = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Square of a 16-bit signed value fits 31 bits; the sum of two fits 32.
  localparam int unsigned SQ_W     = 31;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned SQRT_STEPS = 16;

  // CORDIC datapath: the vector grows by about 1.65, the angle is Q.20 radians.
  localparam int unsigned CV_W     = 20;
  localparam int unsigned ANG_W    = 24;
  localparam int unsigned ANG_FRAC_SHIFT = 8;
  localparam int unsigned TABLE_LEN = 24;

  localparam logic signed [ANG_W-1:0] PI_Q20     = 24'sd3294199;
  localparam logic signed [ANG_W-1:0] TURN_LIMIT = 24'sd12868;
  localparam logic signed [ANG_W-1:0] ANG_HALF   = 24'sd128;

  localparam int unsigned QDEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE = 2'd2;

  typedef struct packed {
    logic [SQ_W-1:0]         xx;
    logic [SQ_W-1:0]         yy;
    logic signed [CV_W-1:0]  cx;
    logic signed [CV_W-1:0]  cy;
    logic signed [ANG_W-1:0] cz;
    logic                    stale;
    logic                    zero;
  } work_t;

  // atan(2^-i) in Q.20 radians, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_q20(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 24'sd823550;
      5'd1:  v = 24'sd486170;
      5'd2:  v = 24'sd256879;
      5'd3:  v = 24'sd130396;
      5'd4:  v = 24'sd65451;
      5'd5:  v = 24'sd32757;
      5'd6:  v = 24'sd16383;
      5'd7:  v = 24'sd8192;
      5'd8:  v = 24'sd4096;
      5'd9:  v = 24'sd2048;
      5'd10: v = 24'sd1024;
      5'd11: v = 24'sd512;
      5'd12: v = 24'sd256;
      5'd13: v = 24'sd128;
      5'd14: v = 24'sd64;
      5'd15: v = 24'sd32;
      5'd16: v = 24'sd16;
      5'd17: v = 24'sd8;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/dhf_front.sv =====
// Front end: accepts an item, squares the offsets, flags stale and zero cases, folds the vector.
module dhf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [dhf_pkg::OFS_W-1:0]  offset_x_i,
  input  logic signed [dhf_pkg::OFS_W-1:0]  offset_y_i,
  input  logic [dhf_pkg::AGE_W-1:0]         target_age_ms_i,
  input  logic [dhf_pkg::STALE_W-1:0]       stale_limit_i,
  input  logic                              full_i,
  output logic                              push_o,
  output dhf_pkg::work_t                    work_o
);

  logic           vld_q;
  dhf_pkg::work_t work_q, work_d;
  logic           accept;

  logic signed [2*dhf_pkg::OFS_W-1:0] px, py;
  logic signed [dhf_pkg::CV_W-1:0]    ex, ey;

  assign push_o = vld_q && !full_i;
  assign busy_o = vld_q && !push_o;
  assign accept = start_i && !busy_o;
  assign work_o = work_q;

  always_comb begin
    px = offset_x_i * offset_x_i;
    py = offset_y_i * offset_y_i;
    ex = dhf_pkg::CV_W'(offset_x_i);
    ey = dhf_pkg::CV_W'(offset_y_i);
    work_d.xx    = px[dhf_pkg::SQ_W-1:0];
    work_d.yy    = py[dhf_pkg::SQ_W-1:0];
    work_d.stale = target_age_ms_i > stale_limit_i;
    work_d.zero  = (offset_x_i == '0) && (offset_y_i == '0);
    // A target behind the follower is turned half a circle before vectoring.
    if (offset_x_i < 0) begin
      work_d.cx = -ex;
      work_d.cy = -ey;
      work_d.cz = (offset_y_i >= 0) ? dhf_pkg::PI_Q20 : -dhf_pkg::PI_Q20;
    end else begin
      work_d.cx = ex;
      work_d.cy = ey;
      work_d.cz = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

endmodule

// ===== design/dhf_queue.sv =====
// Short queue of classified beats between the front end and the back end.
module dhf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dhf_pkg::work_t work_i,
  output logic           full_o,
  output logic           pop_o,
  output dhf_pkg::work_t work_o
);

  localparam int unsigned PTR_W = $clog2(dhf_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(dhf_pkg::QDEPTH + 1);

  dhf_pkg::work_t mem_q [dhf_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o = cnt_q == CNT_W'(dhf_pkg::QDEPTH);
  // The back end never stalls, so any queued beat leaves at once.
  assign pop_o  = cnt_q != '0;
  assign work_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(dhf_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_o) begin
        rd_q <= (rd_q == PTR_W'(dhf_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_o) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_o && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= work_i;
    end
  end

endmodule

// ===== design/dhf_back.sv =====
// Back end: pipelined square root and CORDIC vectoring, then speed and bearing shaping.
module dhf_back #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_i,
  input  dhf_pkg::work_t                     work_i,
  input  logic [dhf_pkg::HOLD_W-1:0]         hold_distance_i,
  input  logic [dhf_pkg::CAP_W-1:0]          speed_cap_i,
  output logic                               done_o,
  output logic [dhf_pkg::SPEED_W-1:0]        linear_speed_o,
  output logic signed [dhf_pkg::TURN_W-1:0]  turn_command_o
);

  localparam int unsigned CS   = (CORDIC_STAGES > dhf_pkg::TABLE_LEN) ?
                                 dhf_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned NSTG = (CS > dhf_pkg::SQRT_STEPS) ? CS : dhf_pkg::SQRT_STEPS;

  logic                            vld_q   [NSTG+1];
  logic [dhf_pkg::SUM_W-1:0]       n_q     [NSTG+1];
  logic [dhf_pkg::SUM_W-1:0]       res_q   [NSTG+1];
  logic signed [dhf_pkg::CV_W-1:0] x_q     [NSTG+1];
  logic signed [dhf_pkg::CV_W-1:0] y_q     [NSTG+1];
  logic signed [dhf_pkg::ANG_W-1:0] z_q    [NSTG+1];
  logic                            stale_q [NSTG+1];
  logic                            zero_q  [NSTG+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= pop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      n_q[0]     <= dhf_pkg::SUM_W'(work_i.xx) + dhf_pkg::SUM_W'(work_i.yy);
      res_q[0]   <= '0;
      x_q[0]     <= work_i.cx;
      y_q[0]     <= work_i.cy;
      z_q[0]     <= work_i.cz;
      stale_q[0] <= work_i.stale;
      zero_q[0]  <= work_i.zero;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic [dhf_pkg::SUM_W-1:0]        n_d, res_d;
    logic signed [dhf_pkg::CV_W-1:0]  x_d, y_d;
    logic signed [dhf_pkg::ANG_W-1:0] z_d;

    if (i < dhf_pkg::SQRT_STEPS) begin : g_sqrt
      localparam logic [dhf_pkg::SUM_W-1:0] BIT = 32'd1 << (30 - 2 * i);
      logic [dhf_pkg::SUM_W-1:0] trial;
      always_comb begin
        trial = res_q[i] + BIT;
        if (n_q[i] >= trial) begin
          n_d   = n_q[i] - trial;
          res_d = (res_q[i] >> 1) + BIT;
        end else begin
          n_d   = n_q[i];
          res_d = res_q[i] >> 1;
        end
      end
    end else begin : g_sqrt_pass
      assign n_d   = n_q[i];
      assign res_d = res_q[i];
    end

    if (i < CS) begin : g_cordic
      logic signed [dhf_pkg::CV_W-1:0] xs, ys;
      always_comb begin
        xs = x_q[i] >>> i;
        ys = y_q[i] >>> i;
        if (y_q[i] >= 0) begin
          x_d = x_q[i] + ys;
          y_d = y_q[i] - xs;
          z_d = z_q[i] + dhf_pkg::atan_q20(5'(i));
        end else begin
          x_d = x_q[i] - ys;
          y_d = y_q[i] + xs;
          z_d = z_q[i] - dhf_pkg::atan_q20(5'(i));
        end
      end
    end else begin : g_cordic_pass
      assign x_d = x_q[i];
      assign y_d = y_q[i];
      assign z_d = z_q[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[i]) begin
        n_q[i+1]     <= n_d;
        res_q[i+1]   <= res_d;
        x_q[i+1]     <= x_d;
        y_q[i+1]     <= y_d;
        z_q[i+1]     <= z_d;
        stale_q[i+1] <= stale_q[i];
        zero_q[i+1]  <= zero_q[i];
      end
    end
  end

  logic [dhf_pkg::DIST_W-1:0]        radius, diff;
  logic [dhf_pkg::SPEED_W-1:0]       speed_d, speed_q;
  logic signed [dhf_pkg::ANG_W-1:0]  zr, zc;
  logic signed [dhf_pkg::TURN_W-1:0] turn_d, turn_q;
  logic                              done_q;

  always_comb begin
    radius = res_q[NSTG][dhf_pkg::DIST_W-1:0];
    diff   = radius - dhf_pkg::DIST_W'(hold_distance_i);
    if (stale_q[NSTG] || radius <= dhf_pkg::DIST_W'(hold_distance_i)) begin
      speed_d = '0;
    end else if (diff >= dhf_pkg::DIST_W'(speed_cap_i)) begin
      speed_d = speed_cap_i;
    end else begin
      speed_d = diff[dhf_pkg::SPEED_W-1:0];
    end

    zr = (z_q[NSTG] + dhf_pkg::ANG_HALF) >>> dhf_pkg::ANG_FRAC_SHIFT;
    if (zr > dhf_pkg::TURN_LIMIT) begin
      zc = dhf_pkg::TURN_LIMIT;
    end else if (zr < -dhf_pkg::TURN_LIMIT) begin
      zc = -dhf_pkg::TURN_LIMIT;
    end else begin
      zc = zr;
    end
    if (stale_q[NSTG] || zero_q[NSTG]) begin
      turn_d = '0;
    end else begin
      turn_d = zc[dhf_pkg::TURN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[NSTG]) begin
      speed_q <= speed_d;
      turn_q  <= turn_d;
    end
  end

  assign done_o         = done_q;
  assign linear_speed_o = speed_q;
  assign turn_command_o = turn_q;

endmodule

// ===== design/distance_hold_follower_core.sv =====
// The pipeline depth from start to done is set by the longer of the
// square-root pipeline (16 steps) and the CORDIC pipeline (one stage per iteration).
// Throughput: one item per cycle; busy stays low because the back end never stalls.
// Each result is shown for one cycle under done_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue and restores the
// registers to hold 1229, cap 307, stale limit 500.
module distance_hold_follower_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [dhf_pkg::OFS_W-1:0]    offset_x_i,
  input  logic signed [dhf_pkg::OFS_W-1:0]    offset_y_i,
  input  logic [dhf_pkg::AGE_W-1:0]           target_age_ms_i,
  output logic                                done_o,
  output logic [dhf_pkg::SPEED_W-1:0]         linear_speed_o,
  output logic signed [dhf_pkg::TURN_W-1:0]   turn_command_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dhf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dhf_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  logic [dhf_pkg::HOLD_W-1:0]  hold_q;
  logic [dhf_pkg::CAP_W-1:0]   cap_q;
  logic [dhf_pkg::STALE_W-1:0] stale_q;
  logic                        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 15'd1229;
      cap_q   <= 15'd307;
      stale_q <= 16'd500;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        dhf_pkg::CFG_HOLD:  hold_q  <= cfg_data_i[dhf_pkg::HOLD_W-1:0];
        dhf_pkg::CFG_CAP:   cap_q   <= cfg_data_i[dhf_pkg::CAP_W-1:0];
        dhf_pkg::CFG_STALE: stale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           push, full, pop;
  dhf_pkg::work_t fw, qw;

  dhf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .offset_x_i      (offset_x_i),
    .offset_y_i      (offset_y_i),
    .target_age_ms_i (target_age_ms_i),
    .stale_limit_i   (stale_q),
    .full_i          (full),
    .push_o          (push),
    .work_o          (fw)
  );

  dhf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .work_i (fw),
    .full_o (full),
    .pop_o  (pop),
    .work_o (qw)
  );

  dhf_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_i           (pop),
    .work_i          (qw),
    .hold_distance_i (hold_q),
    .speed_cap_i     (cap_q),
    .done_o          (done_o),
    .linear_speed_o  (linear_speed_o),
    .turn_command_o  (turn_command_o)
  );

endmodule

// ===== tb/follow_cmd_checker.sv =====
// Checker for the distance-hold follower: predicts each command and compares it with the block.
`timescale 1ns / 100ps

module follow_cmd_checker #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic signed [dhf_pkg::OFS_W-1:0]    offset_x_i,
  input  logic signed [dhf_pkg::OFS_W-1:0]    offset_y_i,
  input  logic [dhf_pkg::AGE_W-1:0]           target_age_ms_i,
  input  logic                                done_i,
  input  logic [dhf_pkg::SPEED_W-1:0]         linear_speed_i,
  input  logic signed [dhf_pkg::TURN_W-1:0]   turn_command_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [dhf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dhf_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  output int                                  mismatches_o,
  output int                                  pending_o
);

  localparam longint PI_ANGLE    = 3294199;
  localparam longint BEARING_MAX = 12868;
  localparam int     ATAN_ENTRIES = 24;
  localparam int     STAGES_RUN  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  typedef struct packed {
    logic [dhf_pkg::SPEED_W-1:0]       speed;
    logic signed [dhf_pkg::TURN_W-1:0] turn;
  } follow_cmd_t;

  // atan(2^-n) in radians with 20 fraction bits.
  longint atan_step [0:ATAN_ENTRIES-1] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };

  logic [dhf_pkg::HOLD_W-1:0]  hold_len;
  logic [dhf_pkg::CAP_W-1:0]   speed_limit;
  logic [dhf_pkg::STALE_W-1:0] stale_lim;
  follow_cmd_t                 pending_cmds[$];
  int                          fail_count = 0;

  assign mismatches_o = fail_count;

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    rem  = n;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [dhf_pkg::TURN_W-1:0] bearing_to(longint x_in,
                                                                   longint y_in);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return '0;
    // A target behind the follower is folded into the right half plane first.
    if (x < 0) begin
      z = (y >= 0) ? PI_ANGLE : -PI_ANGLE;
      x = -x;
      y = -y;
    end
    for (int n = 0; n < STAGES_RUN; n++) begin
      xs = x >>> n;
      ys = y >>> n;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[n];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[n];
      end
    end
    z = (z + 128) >>> 8;
    if (z > BEARING_MAX) z = BEARING_MAX;
    if (z < -BEARING_MAX) z = -BEARING_MAX;
    return z[dhf_pkg::TURN_W-1:0];
  endfunction

  function automatic follow_cmd_t predict_cmd(logic signed [dhf_pkg::OFS_W-1:0] ox,
                                              logic signed [dhf_pkg::OFS_W-1:0] oy,
                                              logic [dhf_pkg::AGE_W-1:0] age);
    follow_cmd_t     cmd;
    longint          sx;
    longint          sy;
    longint unsigned radius;
    longint unsigned spd;
    cmd = '0;
    if (age <= stale_lim) begin
      sx     = ox;
      sy     = oy;
      radius = floor_root(sx * sx + sy * sy);
      if (radius > hold_len) begin
        spd = radius - hold_len;
        if (spd >= speed_limit) spd = speed_limit;
        cmd.speed = spd[dhf_pkg::SPEED_W-1:0];
      end
      cmd.turn = bearing_to(sx, sy);
    end
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    follow_cmd_t want;
    if (!rst_ni) begin
      hold_len    = 15'd1229;
      speed_limit = 15'd307;
      stale_lim   = 16'd500;
      pending_cmds.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          dhf_pkg::CFG_HOLD:  hold_len    = cfg_data_i[dhf_pkg::HOLD_W-1:0];
          dhf_pkg::CFG_CAP:   speed_limit = cfg_data_i[dhf_pkg::CAP_W-1:0];
          dhf_pkg::CFG_STALE: stale_lim   = cfg_data_i[dhf_pkg::STALE_W-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (pending_cmds.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected (speed %0d turn %0d)",
                   $time, linear_speed_i, turn_command_i);
        end else begin
          want = pending_cmds.pop_front();
          if (linear_speed_i !== want.speed) begin
            fail_count++;
            $display("%0t: linear_speed expected %0d actual %0d",
                     $time, want.speed, linear_speed_i);
          end
          if (turn_command_i !== want.turn) begin
            fail_count++;
            $display("%0t: turn_command expected %0d actual %0d",
                     $time, want.turn, turn_command_i);
          end
        end
      end
      if (start_i && !busy_i)
        pending_cmds.push_back(predict_cmd(offset_x_i, offset_y_i, target_age_ms_i));
      pending_o <= pending_cmds.size();
    end
  end

endmodule

// ===== tb/distance_hold_follower_core_tb.sv =====
// Top of the distance-hold follower testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module distance_hold_follower_core_tb;

  localparam int unsigned STAGES      = 16;
  localparam int unsigned LATENCY     = 19;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES      = 6;
  // Index past the last register; a write there must change nothing.
  localparam logic [dhf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  logic signed [dhf_pkg::OFS_W-1:0]    offset_x;
  logic signed [dhf_pkg::OFS_W-1:0]    offset_y;
  logic [dhf_pkg::AGE_W-1:0]           target_age;
  logic                                done;
  logic [dhf_pkg::SPEED_W-1:0]         linear_speed;
  logic signed [dhf_pkg::TURN_W-1:0]   turn_command;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [dhf_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [dhf_pkg::CFG_DAT_W-1:0]       cfg_data;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  int beats = 0;
  int stale_beats = 0;
  int reg_writes = 0;

  logic [dhf_pkg::HOLD_W-1:0]  hold_now  = 15'd1229;
  logic [dhf_pkg::CAP_W-1:0]   cap_now   = 15'd307;
  logic [dhf_pkg::STALE_W-1:0] stale_now = 16'd500;

  distance_hold_follower_core #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .offset_x_i     (offset_x),
    .offset_y_i     (offset_y),
    .target_age_ms_i(target_age),
    .done_o         (done),
    .linear_speed_o (linear_speed),
    .turn_command_o (turn_command),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  follow_cmd_checker #(
    .CORDIC_STAGES(STAGES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .offset_x_i     (offset_x),
    .offset_y_i     (offset_y),
    .target_age_ms_i(target_age),
    .done_i         (done),
    .linear_speed_i (linear_speed),
    .turn_command_i (turn_command),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Holds start high until the block takes the beat; start is left high on return.
  task automatic send_target(input logic signed [dhf_pkg::OFS_W-1:0] x,
                             input logic signed [dhf_pkg::OFS_W-1:0] y,
                             input logic [dhf_pkg::AGE_W-1:0] age);
    start      <= 1'b1;
    offset_x   <= x;
    offset_y   <= y;
    target_age <= age;
    do @(posedge clk_i); while (busy);
    beats++;
    if (age > stale_now) stale_beats++;
  endtask

  task automatic idle_gap(input logic burst);
    int sel;
    int gap;
    sel = $urandom_range(0, 19);
    if (burst || sel < 12) gap = 0;
    else if (sel < 18) gap = $urandom_range(1, 3);
    else if (sel == 18) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start      <= 1'b0;
      offset_x   <= 16'($urandom);
      offset_y   <= 16'($urandom);
      target_age <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drops start and waits until every expected command has come back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [dhf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dhf_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    reg_writes++;
    case (idx)
      dhf_pkg::CFG_HOLD:  hold_now  = data[dhf_pkg::HOLD_W-1:0];
      dhf_pkg::CFG_CAP:   cap_now   = data[dhf_pkg::CAP_W-1:0];
      dhf_pkg::CFG_STALE: stale_now = data[dhf_pkg::STALE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [dhf_pkg::OFS_W-1:0] extreme_ofs();
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  task automatic pick_offsets(output logic signed [dhf_pkg::OFS_W-1:0] x,
                              output logic signed [dhf_pkg::OFS_W-1:0] y);
    int r;
    int side;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      4, 5: begin
        x = 16'(int'($urandom_range(0, 4095)) - 2048);
        y = 16'(int'($urandom_range(0, 4095)) - 2048);
      end
      6, 7: begin
        // Distances around the hold ring and the speed cap.
        r = int'(hold_now) + int'($urandom_range(0, int'(cap_now) + 64)) - 32;
        if (r < 0) r = 0;
        if (r > 32767) r = 32767;
        if ($urandom_range(0, 1)) r = -r;
        side = int'($urandom_range(0, 32)) - 16;
        if ($urandom_range(0, 1)) begin
          x = 16'(r);
          y = 16'(side);
        end else begin
          x = 16'(side);
          y = 16'(r);
        end
      end
      8: begin
        x = extreme_ofs();
        y = extreme_ofs();
      end
      default: begin
        // Behind the follower, right on the pi seam.
        x = 16'(-int'($urandom_range(1, 32768)));
        y = $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
      end
    endcase
  endtask

  function automatic logic [dhf_pkg::AGE_W-1:0] pick_age();
    case ($urandom_range(0, 9))
      0: return stale_now;
      1: return (stale_now == 16'hFFFF) ? stale_now : stale_now + 16'd1;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, int'(stale_now)));
    endcase
  endfunction

  task automatic configure_phase(input int phase);
    case (phase)
      1: begin
        write_reg(dhf_pkg::CFG_HOLD, 16'h0000);
        write_reg(dhf_pkg::CFG_CAP, 16'hFFFF);
        write_reg(dhf_pkg::CFG_STALE, 16'hFFFF);
      end
      2: begin
        write_reg(dhf_pkg::CFG_HOLD, 16'hFFFF);
        write_reg(dhf_pkg::CFG_CAP, 16'h0000);
        write_reg(dhf_pkg::CFG_STALE, 16'h0000);
      end
      3: begin
        write_reg(dhf_pkg::CFG_HOLD, 16'($urandom_range(0, 4000)));
        write_reg(dhf_pkg::CFG_CAP, 16'($urandom_range(0, 3000)));
        write_reg(dhf_pkg::CFG_STALE, 16'($urandom));
        write_reg(CFG_SPARE, 16'($urandom));
      end
      4: begin
        write_reg(dhf_pkg::CFG_HOLD, 16'd100);
        write_reg(dhf_pkg::CFG_CAP, 16'd2000);
        write_reg(dhf_pkg::CFG_STALE, 16'd1000);
      end
      5: begin
        write_reg(dhf_pkg::CFG_STALE, 16'($urandom));
        write_reg(dhf_pkg::CFG_CAP, 16'($urandom));
        write_reg(dhf_pkg::CFG_HOLD, 16'($urandom_range(0, 8000)));
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Runs under the reset settings: hold 1229, cap 307, stale limit 500.
  task automatic directed_targets;
    send_target(16'sd0, 16'sd0, 16'd0);
    send_target(16'sd32767, 16'sd0, 16'd0);
    send_target(-16'sd32768, 16'sd0, 16'd0);
    send_target(16'sd0, 16'sd32767, 16'd0);
    send_target(16'sd0, -16'sd32768, 16'd0);
    send_target(-16'sd32768, -16'sd32768, 16'd0);
    send_target(16'sd32767, 16'sd32767, 16'd0);
    send_target(-16'sd32768, 16'sd32767, 16'd0);
    send_target(16'sd32767, -16'sd32768, 16'd0);
    send_target(-16'sd1, 16'sd0, 16'd0);
    send_target(-16'sd1, -16'sd1, 16'd0);
    send_target(-16'sd5, 16'sd3, 16'd0);
    send_target(16'sd1229, 16'sd0, 16'd0);
    send_target(16'sd1230, 16'sd0, 16'd0);
    send_target(16'sd1536, 16'sd0, 16'd0);
    send_target(16'sd1600, 16'sd0, 16'd0);
    send_target(16'sd0, -16'sd1300, 16'd0);
    send_target(16'sd2000, 16'sd2000, 16'd500);
    send_target(16'sd2000, 16'sd2000, 16'd501);
    send_target(-16'sd3000, -16'sd100, 16'hFFFF);
    send_target(16'sd1, 16'sd1, 16'd0);
    send_target(16'sd3, -16'sd4, 16'd0);
  endtask

  initial begin
    int n_items;
    logic signed [dhf_pkg::OFS_W-1:0] x;
    logic signed [dhf_pkg::OFS_W-1:0] y;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    offset_x   <= '0;
    offset_y   <= '0;
    target_age <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) drain();
      configure_phase(phase);
      if (phase == 0) directed_targets();
      case (phase)
        2:       n_items = 150;
        3:       n_items = 250;
        default: n_items = 200;
      endcase
      repeat (n_items) begin
        pick_offsets(x, y);
        send_target(x, y, pick_age());
        idle_gap(phase == 4);
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Covered %0d target beats (%0d stale) under %0d register settings, %0d writes.",
             beats, stale_beats, PHASES, reg_writes);
    $display("Directed extremes, hold ring and cap edges, pi seam and stale ages included.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dhf_pkg.sv
design/dhf_front.sv
design/dhf_queue.sv
design/dhf_back.sv
design/distance_hold_follower_core.sv
tb/follow_cmd_checker.sv
tb/distance_hold_follower_core_tb.sv
